// ===== src/ttint_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the timed track interpolator
package ttint_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic        [31:0] point_time_in;
        logic signed [39:0] point_x_in;
        logic signed [39:0] point_y_in;
        logic signed [39:0] point_z_in;
        logic        [31:0] query_time;
    } t_in_beat;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic signed [39:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_upd;
        logic seg;
        logic rd1;
        logic rd2;
        logic lat2;
        logic set_zero;
        logic div_start;
        logic div_step;
        logic mul_init;
        logic mul_step;
        logic fin;
        logic deliver;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic srch_done;
        logic zero_seg;
    } t_stat;

endpackage

// ===== src/ttint_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per step, 64-bit dividend by 32-bit divisor
module ttint_div (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic        i_step,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [32:0] o_quot,
    output logic        o_ovf
);

    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] r_quot;
    logic        r_ovf;
    logic [32:0] rem_s;
    logic [32:0] diff;
    logic        ge;

    assign rem_s = {r_rem, r_num[63]};
    assign diff  = rem_s - {1'b0, r_den};
    assign ge    = rem_s >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= ge ? diff[31:0] : rem_s[31:0];
            r_quot <= {r_quot[31:0], ge};
            r_ovf  <= r_ovf | r_quot[32];
        end
    end

    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

// ===== src/ttint_dp.sv =====
`timescale 1ns / 1ps
// datapath: point memory, search registers, dividers, serial multipliers, result registers
module ttint_dp import ttint_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in_data,
    output t_stat     o_stat,
    output t_out_beat o_out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int MW = 152;

    logic [MW-1:0] r_mem [MAX_POINTS];
    logic [MW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [31:0]   r_qt;
    logic [AW-1:0] r_idx;
    logic          r_clamp_lo;
    logic          r_clamp_hi;
    logic [31:0]   r_t1;
    logic [39:0]   r_x1;
    logic [39:0]   r_y1;
    logic [39:0]   r_z1;
    logic [31:0]   r_dt;
    logic [31:0]   r_el;
    logic [40:0]   r_dx;
    logic [40:0]   r_dy;
    logic [40:0]   r_dz;
    logic          r_zero;
    logic [32:0]   r_fsh;
    logic [72:0]   r_acc_x;
    logic [72:0]   r_acc_y;
    logic [72:0]   r_acc_z;
    t_out_beat     r_res;
    t_out_beat     r_out;

    logic          full;
    logic          few;
    logic [CW:0]   mid_w;
    logic [CW-1:0] mid;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   t2;
    logic [31:0]   dt;
    logic [31:0]   el_raw;
    logic [31:0]   el;
    logic [39:0]   mag_x;
    logic [39:0]   mag_y;
    logic [39:0]   mag_z;
    logic [32:0]   q_f;
    logic [32:0]   q_vx;
    logic [32:0]   q_vy;
    logic          ovf_f;
    logic          ovf_vx;
    logic          ovf_vy;
    logic [40:0]   off_x;
    logic [40:0]   off_y;
    logic [40:0]   off_z;

    function automatic logic [39:0] mag40(input logic [40:0] d);
        logic [40:0] m;
        begin
            m = d[40] ? (41'd0 - d) : d;
            return m[39:0];
        end
    endfunction

    function automatic logic [31:0] vel_sat(input logic neg, input logic [32:0] q,
                                            input logic ovf);
        logic sat;
        begin
            if (neg) begin
                sat = ovf | q[32] | (q[31] & (|q[30:0]));
                return sat ? 32'h8000_0000 : (32'd0 - q[31:0]);
            end else begin
                sat = ovf | q[32] | q[31];
                return sat ? 32'h7FFF_FFFF : q[31:0];
            end
        end
    endfunction

    assign full  = r_count == CW'(MAX_POINTS);
    assign few   = r_count < CW'(2);
    assign mid_w = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign mid   = mid_w[CW-1:0];

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        if (i_cmd.srch_rd) begin
            rd_en   = 1'b1;
            rd_addr = mid[AW-1:0];
        end else if (i_cmd.rd1) begin
            rd_en   = 1'b1;
            rd_addr = r_idx;
        end else if (i_cmd.rd2) begin
            rd_en   = 1'b1;
            rd_addr = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_in_data.opcode == OP_APPEND && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_in_data.point_time_in, i_in_data.point_x_in,
                                       i_in_data.point_y_in, i_in_data.point_z_in};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign t2     = r_rd[151:120];
    assign dt     = t2 - r_t1;
    assign el_raw = r_clamp_lo ? 32'd0 :
                    r_clamp_hi ? dt :
                    (r_qt > r_t1) ? (r_qt - r_t1) : 32'd0;
    assign el     = (el_raw > dt) ? dt : el_raw;
    assign mag_x  = mag40(r_dx);
    assign mag_y  = mag40(r_dy);
    assign mag_z  = mag40(r_dz);

    ttint_div u_div_f (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   ({r_el, 32'd0}),
        .i_den   (r_dt),
        .o_quot  (q_f),
        .o_ovf   (ovf_f)
    );

    ttint_div u_div_vx (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   ({mag_x, 24'd0}),
        .i_den   (r_dt),
        .o_quot  (q_vx),
        .o_ovf   (ovf_vx)
    );

    ttint_div u_div_vy (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   ({mag_y, 24'd0}),
        .i_den   (r_dt),
        .o_quot  (q_vy),
        .o_ovf   (ovf_vy)
    );

    assign off_x = r_acc_x[72:32];
    assign off_y = r_acc_y[72:32];
    assign off_z = r_acc_z[72:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            if (i_in_data.opcode == OP_CLEAR) begin
                r_count <= '0;
            end else if (i_in_data.opcode == OP_APPEND && !full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_qt  <= i_in_data.query_time;
            r_res <= '0;
            if (i_in_data.opcode == OP_APPEND && full) begin
                r_res.status <= ST_FULL;
            end else if (i_in_data.opcode == OP_QUERY && few) begin
                r_res.status <= ST_FEW;
            end else begin
                r_res.status <= ST_OK;
            end
        end
        if (i_cmd.srch_upd) begin
            if (r_rd[151:120] < r_qt) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.seg) begin
            r_clamp_lo <= r_lo == '0;
            r_clamp_hi <= r_lo >= r_count;
            if (r_lo == '0) begin
                r_idx <= '0;
            end else if (r_lo >= r_count) begin
                r_idx <= AW'(r_count - CW'(2));
            end else begin
                r_idx <= AW'(r_lo - CW'(1));
            end
        end
        if (i_cmd.rd2) begin
            r_t1 <= r_rd[151:120];
            r_x1 <= r_rd[119:80];
            r_y1 <= r_rd[79:40];
            r_z1 <= r_rd[39:0];
        end
        if (i_cmd.lat2) begin
            r_zero <= t2 <= r_t1;
            r_dt   <= dt;
            r_el   <= el;
            r_dx   <= {r_rd[119], r_rd[119:80]} - {r_x1[39], r_x1};
            r_dy   <= {r_rd[79], r_rd[79:40]} - {r_y1[39], r_y1};
            r_dz   <= {r_rd[39], r_rd[39:0]} - {r_z1[39], r_z1};
        end
        if (i_cmd.set_zero) begin
            r_res        <= '0;
            r_res.status <= ST_ZERO;
        end
        if (i_cmd.mul_init) begin
            r_fsh   <= q_f;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_cmd.mul_step) begin
            r_fsh   <= {r_fsh[31:0], 1'b0};
            r_acc_x <= {r_acc_x[71:0], 1'b0} + (r_fsh[32] ? 73'(mag_x) : 73'd0);
            r_acc_y <= {r_acc_y[71:0], 1'b0} + (r_fsh[32] ? 73'(mag_y) : 73'd0);
            r_acc_z <= {r_acc_z[71:0], 1'b0} + (r_fsh[32] ? 73'(mag_z) : 73'd0);
        end
        if (i_cmd.fin) begin
            r_res.status <= ST_OK;
            r_res.pos_x  <= r_dx[40] ? (r_x1 - off_x[39:0]) : (r_x1 + off_x[39:0]);
            r_res.pos_y  <= r_dy[40] ? (r_y1 - off_y[39:0]) : (r_y1 + off_y[39:0]);
            r_res.pos_z  <= r_dz[40] ? (r_z1 - off_z[39:0]) : (r_z1 + off_z[39:0]);
            r_res.vel_x  <= vel_sat(r_dx[40], q_vx, ovf_vx);
            r_res.vel_y  <= vel_sat(r_dy[40], q_vy, ovf_vy);
        end
        if (i_cmd.deliver) begin
            r_out <= r_res;
        end
    end

    assign o_stat.few       = few;
    assign o_stat.srch_done = r_lo >= r_hi;
    assign o_stat.zero_seg  = r_zero | ovf_f;
    assign o_out_data       = r_out;

endmodule

// ===== src/ttint_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences search, segment reads, division, multiply and delivery
module ttint_ctrl import ttint_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  [1:0] i_opcode,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [6:0] DIV_LAST = 7'd63;
    localparam logic [6:0] MUL_LAST = 7'd32;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_SEG, S_RD1, S_RD2, S_LAT2, S_CHK,
        S_DIV, S_MULI, S_MUL, S_FIN, S_DLV
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [6:0] r_cnt;
    logic [6:0] n_cnt;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign accept     = i_in_valid && r_state == S_IDLE;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_opcode == OP_QUERY && !i_stat.few) ? S_SRD : S_DLV;
                end
            end
            S_SRD: begin
                if (i_stat.srch_done) begin
                    n_state = S_SEG;
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SRD;
            end
            S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_LAT2;
            end
            S_LAT2: begin
                o_cmd.lat2 = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_stat.zero_seg) begin
                    o_cmd.set_zero = 1'b1;
                    n_state        = S_DLV;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 7'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MULI;
                end
            end
            S_MULI: begin
                o_cmd.mul_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 7'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DLV;
            end
            S_DLV: begin
                if (out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_deliver_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.deliver |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a waiting beat");

    a_deliver_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.deliver |=> r_out_valid)
        else $error("delivered result not presented");

    a_short_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_QUERY && i_stat.few) |=> r_state == S_DLV)
        else $error("short table query did not go straight to delivery");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divide step count overran");

endmodule

// ===== src/timed_track_interpolator_top.sv =====
`timescale 1ns / 1ps
// Timed track interpolator: keeps up to MAX_POINTS time-stamped points in one
// single-port memory and answers clear, append and query beats, one at a time.
// A clear, append or unused opcode goes straight from taking the input beat to
// loading the output register. A query with fewer than two points does the
// same; otherwise it runs the binary search steps through the memory read
// port, the segment reads and checks, 64 steps of the bit-serial dividers
// (fraction and both velocities in parallel), a setup step and 33 steps of
// the shift-add multipliers for the three position offsets, then finishes
// and loads the output register, which waits until that register is free.
// A finished result waits in the output register while the next beat is taken.
module timed_track_interpolator_top import ttint_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    ttint_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ttint_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sim/timed_track_interpolator_checker.sv =====
`timescale 1ns / 1ps
// checker for the timed track interpolator: predicts each result beat and compares
module timed_track_interpolator_checker import ttint_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic        [31:0] trk_t [MAX_POINTS];
    logic signed [39:0] trk_x [MAX_POINTS];
    logic signed [39:0] trk_y [MAX_POINTS];
    logic signed [39:0] trk_z [MAX_POINTS];
    int unsigned trk_len;
    t_out_beat result_q[$];

    assign o_pending = result_q.size();

    function automatic logic signed [39:0] lerp_axis(logic signed [39:0] p1,
            logic signed [40:0] d, logic [32:0] frac);
        logic [40:0]  mag;
        logic [73:0]  prod;
        logic [41:0]  off;
        mag  = d[40] ? 41'(-d) : 41'(d);
        prod = 74'(mag) * 74'(frac);
        off  = 42'(prod >> 32);
        return d[40] ? 40'(p1 - off) : 40'(p1 + off);
    endfunction

    function automatic logic signed [31:0] axis_speed(logic signed [40:0] d,
            logic [31:0] dt);
        logic [40:0] mag;
        logic [64:0] q;
        mag = d[40] ? 41'(-d) : 41'(d);
        q = (65'(mag) << 24) / 65'(dt);
        if (d[40])
            return (q > 65'h80000000) ? 32'h80000000 : 32'(-q);
        return (q > 65'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(q);
    endfunction

    function automatic t_out_beat track_query(logic [31:0] tq);
        t_out_beat r;
        int unsigned lo, hi, mid, i;
        logic [31:0] t, t1, t2, dt;
        logic [63:0] el;
        logic [32:0] frac;
        logic signed [40:0] dx, dy, dz;
        r = '0;
        if (trk_len < 2) begin
            r.status = ST_FEW;
            return r;
        end
        t = tq; lo = 0; hi = trk_len;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (trk_t[mid] < t) lo = mid + 1;
            else hi = mid;
        end
        if (lo == 0) begin
            i = 0; t = trk_t[0];
        end else if (lo >= trk_len) begin
            i = trk_len - 2; t = trk_t[trk_len - 1];
        end else begin
            i = lo - 1;
        end
        t1 = trk_t[i]; t2 = trk_t[i + 1];
        if (t2 <= t1) begin
            r.status = ST_ZERO;
            return r;
        end
        dt = t2 - t1;
        el = (t > t1) ? 64'(t - t1) : 64'd0;
        if (el > dt) el = dt;
        frac = 33'((el << 32) / dt);
        dx = 41'(trk_x[i + 1]) - 41'(trk_x[i]);
        dy = 41'(trk_y[i + 1]) - 41'(trk_y[i]);
        dz = 41'(trk_z[i + 1]) - 41'(trk_z[i]);
        r.status = ST_OK;
        r.pos_x = lerp_axis(trk_x[i], dx, frac);
        r.pos_y = lerp_axis(trk_y[i], dy, frac);
        r.pos_z = lerp_axis(trk_z[i], dz, frac);
        r.vel_x = axis_speed(dx, dt);
        r.vel_y = axis_speed(dy, dt);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat r, want;
        if (!i_rst_n) begin
            trk_len = 0;
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                r = '0;
                case (i_in_data.opcode)
                    OP_CLEAR: trk_len = 0;
                    OP_APPEND: begin
                        if (trk_len >= MAX_POINTS) begin
                            r.status = ST_FULL;
                        end else begin
                            trk_t[trk_len] = i_in_data.point_time_in;
                            trk_x[trk_len] = i_in_data.point_x_in;
                            trk_y[trk_len] = i_in_data.point_y_in;
                            trk_z[trk_len] = i_in_data.point_z_in;
                            trk_len = trk_len + 1;
                        end
                    end
                    OP_QUERY: r = track_query(i_in_data.query_time);
                    default: ;
                endcase
                result_q = {result_q, r};
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp st=%0d p=%h %h %h v=%h %h got st=%0d p=%h %h %h v=%h %h",
                                want.status, want.pos_x, want.pos_y, want.pos_z,
                                want.vel_x, want.vel_y, i_out_data.status,
                                i_out_data.pos_x, i_out_data.pos_y, i_out_data.pos_z,
                                i_out_data.vel_x, i_out_data.vel_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/timed_track_interpolator_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the timed track interpolator: stimulus, handshake pacing and verdict
module timed_track_interpolator_top_tb import ttint_pkg::*; ();

    localparam int MAXP = 1024;
    localparam int WATCHDOG = 5000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_data;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    int        track_len;

    timed_track_interpolator_top #(.MAX_POINTS(MAXP)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    timed_track_interpolator_checker #(.MAX_POINTS(MAXP)) i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pacing
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            repeat (gap) @(posedge i_clk);
            out_stall <= 1'b0;
            @(posedge i_clk iff out_valid);
            out_stall <= 1'b1;
        end
    end

    function automatic logic [39:0] rand40();
        case ($urandom_range(0, 5))
            0: return 40'h7FFFFFFFFF;
            1: return 40'h8000000000;
            2: return {$urandom(), 8'($urandom())};
            default: return 40'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic send_beat(logic [1:0] op, logic [31:0] pt, logic [39:0] px,
            logic [39:0] py, logic [39:0] pz, logic [31:0] qt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{op, pt, px, py, pz, qt};
        @(posedge i_clk iff !in_stall);
        if (op == OP_CLEAR) track_len = 0;
        else if (op == OP_APPEND && track_len < MAXP) track_len++;
    endtask

    task automatic build_track(int n, logic [31:0] t0, int step_max);
        logic [31:0] t;
        t = t0;
        send_beat(OP_CLEAR, $urandom(), rand40(), rand40(), rand40(), $urandom());
        for (int k = 0; k < n; k++) begin
            send_beat(OP_APPEND, t, rand40(), rand40(), rand40(), $urandom());
            t = t + $urandom_range(0, step_max);
        end
    endtask

    initial begin
        logic [31:0] q;
        int sent, n;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        idle_cycles = 0;
        track_len = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: too few points, extremes, zero-length, clamps, unused opcode
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_beat(OP_APPEND, 32'h00010000, 40'h7FFFFFFFFF, 40'h8000000000, 0, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 0);
        send_beat(OP_APPEND, 32'h00010001, 40'h8000000000, 40'h7FFFFFFFFF,
                  40'hFFFFFFFFFF, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'h00010000);
        send_beat(OP_APPEND, 32'hFFFFFFFF, 40'h0000000100, 40'h0, 40'h7FFFFFFFFF, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'h80000000);
        send_beat(OP_APPEND, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_beat(OP_APPEND, 32'h00000005, 40'h55, 40'hAA, 40'h1, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_beat(2'd3, 32'hFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF,
                  32'hFFFFFFFF);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'h00000007);
        send_beat(OP_CLEAR, 0, 0, 0, 0, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 32'h1234);

        // random tracks with queries
        sent = 17;
        while (sent < 600) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            build_track(n, $urandom_range(0, 32'h7FFFFFFF),
                        ($urandom_range(0, 1)) ? 8 : 32'h00FFFFFF);
            sent += n + 1;
            for (int k = 0; k < $urandom_range(2, 8); k++) begin
                case ($urandom_range(0, 9))
                    0: send_beat(2'd3, $urandom(), rand40(), rand40(), rand40(), $urandom());
                    1: send_beat(OP_APPEND, $urandom(), rand40(), rand40(), rand40(),
                                 $urandom());
                    default: begin
                        q = ($urandom_range(0, 4) == 0) ? $urandom()
                          : $urandom_range(0, 32'hFFFFFFFF);
                        send_beat(OP_QUERY, $urandom(), rand40(), rand40(), rand40(), q);
                    end
                endcase
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
